[rtl/xs_pkg.sv]
// Shared types, constants and the state-advance function of the xoshiro256** generator.
package xs_pkg;

  localparam logic [63:0] SplitGolden = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] SplitMulA   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] SplitMulB   = 64'h94D049BB133111EB;

  localparam logic CmdDraw   = 1'b0;
  localparam logic CmdReseed = 1'b1;

  typedef logic [3:0][63:0] words_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAW,
    ST_EMIT,
    ST_ADD,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MIX
  } state_e;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned k);
    rotl = (x << k) | (x >> (64 - k));
  endfunction

  function automatic words_t advance(input words_t w);
    words_t     n;
    logic [63:0] shifted;
    shifted = w[1] << 17;
    n = w;
    n[2] = n[2] ^ n[0];
    n[3] = n[3] ^ n[1];
    n[1] = n[1] ^ n[2];
    n[0] = n[0] ^ n[3];
    n[2] = n[2] ^ shifted;
    n[3] = rotl(n[3], 45);
    advance = n;
  endfunction

endpackage

[rtl/xs_mul32.sv]
// Shared 32x32 multiplier with registered 64-bit product.
module xs_mul32 (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= {32'd0, a_i} * {32'd0, b_i};
  end

  assign prod_o = prod_q;

endmodule

[rtl/xoshiro256ss_generator.sv]
// Top level of the xoshiro256** generator with splitmix64 seeding.
//
//  channel | direction | handshake              | beat fields
//  --------+-----------+------------------------+-----------------------
//  in      | input     | in_valid_i / in_stall_o  | command_i, seed_i
//  out     | output    | out_valid_o / out_stall_i| value_o, fraction_o
//
// A draw runs accept (ST_IDLE), output mix (ST_DRAW), advance and emit (ST_EMIT).
// Per state word a reseed runs ST_ADD, then ST_MUL0-ST_MUL3 and ST_MIX per multiply:
// the 32x32 multiplier forms each 64-bit product from three partial products.
// After reset the block runs the seed-zero expansion with in_stall_o high.
// A draw waits in ST_EMIT while a previous beat is still stalled.
module xoshiro256ss_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [63:0] seed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] value_o,
  output logic [52:0] fraction_o
);

  xs_pkg::state_e state_q, state_d;
  xs_pkg::words_t words_q, words_d;
  logic [63:0]    cnt_q, cnt_d;
  logic [63:0]    z_q, z_d;
  logic [63:0]    acc_q, acc_d;
  logic [63:0]    value_q, value_d;
  logic [1:0]     k_q, k_d;
  logic           sel_q, sel_d;
  logic           out_valid_q, out_valid_d;
  logic [63:0]    mul_const;
  logic [31:0]    mul_a, mul_b;
  logic [63:0]    prod;
  logic [63:0]    cnt_next;
  logic [63:0]    z5;

  assign mul_const = sel_q ? xs_pkg::SplitMulB : xs_pkg::SplitMulA;
  assign cnt_next  = cnt_q + xs_pkg::SplitGolden;
  assign z5        = words_q[1] + (words_q[1] << 2);

  xs_mul32 u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  always_comb begin
    state_d     = state_q;
    words_d     = words_q;
    cnt_d       = cnt_q;
    z_d         = z_q;
    acc_d       = acc_q;
    value_d     = value_q;
    k_d         = k_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = 1'b1;
    mul_a       = z_q[31:0];
    mul_b       = mul_const[31:0];
    unique case (state_q)
      xs_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (command_i == xs_pkg::CmdReseed) begin
            cnt_d   = seed_i;
            k_d     = 2'd0;
            sel_d   = 1'b0;
            state_d = xs_pkg::ST_ADD;
          end else begin
            state_d = xs_pkg::ST_DRAW;
          end
        end
      end
      xs_pkg::ST_DRAW: begin
        z_d     = xs_pkg::rotl(z5, 7);
        state_d = xs_pkg::ST_EMIT;
      end
      xs_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          value_d     = z_q + (z_q << 3);
          out_valid_d = 1'b1;
          words_d     = xs_pkg::advance(words_q);
          state_d     = xs_pkg::ST_IDLE;
        end
      end
      xs_pkg::ST_ADD: begin
        cnt_d   = cnt_next;
        z_d     = cnt_next ^ (cnt_next >> 30);
        state_d = xs_pkg::ST_MUL0;
      end
      xs_pkg::ST_MUL0: begin
        state_d = xs_pkg::ST_MUL1;
      end
      xs_pkg::ST_MUL1: begin
        mul_a   = z_q[63:32];
        acc_d   = prod;
        state_d = xs_pkg::ST_MUL2;
      end
      xs_pkg::ST_MUL2: begin
        mul_b        = mul_const[63:32];
        acc_d[63:32] = acc_q[63:32] + prod[31:0];
        state_d      = xs_pkg::ST_MUL3;
      end
      xs_pkg::ST_MUL3: begin
        acc_d[63:32] = acc_q[63:32] + prod[31:0];
        state_d      = xs_pkg::ST_MIX;
      end
      xs_pkg::ST_MIX: begin
        if (!sel_q) begin
          z_d     = acc_q ^ (acc_q >> 27);
          sel_d   = 1'b1;
          state_d = xs_pkg::ST_MUL0;
        end else begin
          words_d[k_q] = acc_q ^ (acc_q >> 31);
          sel_d        = 1'b0;
          k_d          = k_q + 2'd1;
          state_d      = (k_q == 2'd3) ? xs_pkg::ST_IDLE : xs_pkg::ST_ADD;
        end
      end
      default: begin
        state_d = xs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xs_pkg::ST_ADD;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= 64'd0;
      k_q         <= 2'd0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    words_q <= words_d;
    z_q     <= z_d;
    acc_q   <= acc_d;
    value_q <= value_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign fraction_o  = value_q[63:11];

endmodule

[rtl/xs_checker.sv]
// Port-level checker for the xoshiro256** generator and its bind.
module xs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        command_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] value_o,
  input logic [52:0] fraction_o
);

  logic in_beat;

  assign in_beat = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o))
    else $error("stalled output beat changed");

  a_fraction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fraction_o == value_o[63:11])
    else $error("fraction does not match value");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> in_stall_o)
    else $error("accepted a beat while busy");

  a_reseed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && command_i && !out_valid_o |=> !out_valid_o)
    else $error("reseed produced an output beat");

endmodule

bind xoshiro256ss_generator xs_checker u_xs_checker (.*);

[verif/tb.sv]
// Testbench for the xoshiro256** generator: directed seeds, then random draw and reseed traffic.
`timescale 1ns / 100ps

module tb;

  localparam logic [63:0] GoldenStep = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MixMulA    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MixMulB    = 64'h94D049BB133111EB;
  localparam int          CycleLimit = 500000;
  localparam int          DrainWait  = 60;

  typedef struct packed {
    logic [63:0] value;
    logic [52:0] fraction;
  } draw_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        command_i;
  logic [63:0] seed_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] value_o;
  logic [52:0] fraction_o;

  logic [63:0] gen_state [4];
  draw_t       pending_draws [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          stall_pct = 0;
  int          stall_max = 0;
  int          stall_left = 0;

  xoshiro256ss_generator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .seed_i      (seed_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .fraction_o  (fraction_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [63:0] splitmix_mix(input logic [63:0] ctr);
    logic [63:0] z;
    z = (ctr ^ (ctr >> 30)) * MixMulA;
    z = (z ^ (z >> 27)) * MixMulB;
    return z ^ (z >> 31);
  endfunction

  task automatic load_seed(input logic [63:0] seed);
    logic [63:0] ctr;
    ctr = seed;
    for (int k = 0; k < 4; k++) begin
      ctr = ctr + GoldenStep;
      gen_state[k] = splitmix_mix(ctr);
    end
  endtask

  task automatic predict_draw();
    logic [63:0] prod;
    logic [63:0] outv;
    logic [63:0] shl;
    draw_t       d;
    prod = gen_state[1] * 64'd5;
    outv = {prod[56:0], prod[63:57]} * 64'd9;
    shl  = gen_state[1] << 17;
    gen_state[2] = gen_state[2] ^ gen_state[0];
    gen_state[3] = gen_state[3] ^ gen_state[1];
    gen_state[1] = gen_state[1] ^ gen_state[2];
    gen_state[0] = gen_state[0] ^ gen_state[3];
    gen_state[2] = gen_state[2] ^ shl;
    gen_state[3] = {gen_state[3][18:0], gen_state[3][63:19]};
    d.value    = outv;
    d.fraction = outv[63:11];
    pending_draws.push_back(d);
  endtask

  task automatic send_beat(input logic cmd, input logic [63:0] seed);
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    seed_i     <= seed;
    do @(posedge clk_i); while (in_stall_o);
    if (cmd == xs_pkg::CmdReseed) begin
      load_seed(seed);
    end else begin
      predict_draw();
    end
  endtask

  function automatic logic [63:0] pick_seed();
    case ($urandom_range(7))
      0: return 64'd0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic run_bursts(input int count, input int reseed_pct, input int max_gap);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < count; i++) begin
        if ($urandom_range(99) < reseed_pct) begin
          send_beat(xs_pkg::CmdReseed, pick_seed());
        end else begin
          send_beat(xs_pkg::CmdDraw, {$urandom, $urandom});
        end
        sent++;
      end
      if (max_gap > 0 && $urandom_range(3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, max_gap)) @(posedge clk_i);
      end
    end
  endtask

  task automatic test_reset_expansion();
    stall_pct = 0;
    repeat (4) send_beat(xs_pkg::CmdDraw, 64'd0);
  endtask

  task automatic test_seed_extremes();
    logic [63:0] seeds [6];
    seeds[0] = 64'd0;
    seeds[1] = '1;
    seeds[2] = 64'h8000_0000_0000_0000;
    seeds[3] = 64'hAAAA_AAAA_AAAA_AAAA;
    seeds[4] = 64'h5555_5555_5555_5555;
    seeds[5] = ~GoldenStep + 64'd1;
    foreach (seeds[i]) begin
      send_beat(xs_pkg::CmdReseed, seeds[i]);
      send_beat(xs_pkg::CmdDraw, 64'd0);
    end
    send_beat(xs_pkg::CmdReseed, 64'd1);
    send_beat(xs_pkg::CmdReseed, 64'h0123_4567_89AB_CDEF);
    send_beat(xs_pkg::CmdDraw, 64'd0);
    send_beat(xs_pkg::CmdDraw, 64'd0);
  endtask

  task automatic test_ignored_seed();
    send_beat(xs_pkg::CmdDraw, '1);
    send_beat(xs_pkg::CmdDraw, 64'h8000_0000_0000_0001);
    send_beat(xs_pkg::CmdDraw, {$urandom, $urandom});
  endtask

  task automatic test_full_rate();
    stall_pct = 0;
    run_bursts(200, 3, 0);
  endtask

  task automatic test_stalled_output();
    stall_pct = 60;
    stall_max = 7;
    run_bursts(200, 3, 3);
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 5; ph++) begin
      stall_pct = 20 * $urandom_range(4);
      stall_max = $urandom_range(8);
      run_bursts(86, 5, $urandom_range(6));
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(stall_max);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    draw_t d;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_draws.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got value %h", $time, value_o);
        mismatch_count++;
      end else begin
        d = pending_draws.pop_front();
        if (value_o !== d.value) begin
          $display("%0t: value expected %h got %h", $time, d.value, value_o);
          mismatch_count++;
        end
        if (fraction_o !== d.fraction) begin
          $display("%0t: fraction expected %h got %h", $time, d.fraction, fraction_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    command_i  <= xs_pkg::CmdDraw;
    seed_i     <= 64'd0;
    load_seed(64'd0);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_expansion();
    test_seed_extremes();
    test_ignored_seed();
    test_full_rate();
    test_stalled_output();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_count == 0 && pending_draws.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
